// File: src/tis_pkg.sv
// Shared types and constants for the telnet IAC stripper.
// No dependencies; imported by telnet_iac_stripper_unit.
package tis_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] half_t;

    // Output beat layout: data byte, columns, rows from the lowest bit up
    localparam int unsigned TDATA_W = 40;
    typedef logic [TDATA_W-1:0] out_data_t;

    // Result kinds carried on tuser
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_SIZE = 1'b1;

    // Characters and telnet codes
    localparam byte_t CH_CR   = 8'h0D;
    localparam byte_t CH_LF   = 8'h0A;
    localparam byte_t CH_NUL  = 8'h00;
    localparam byte_t TN_IAC  = 8'd255;
    localparam byte_t TN_NOP  = 8'd241;
    localparam byte_t TN_SB   = 8'd250;
    localparam byte_t TN_NAWS = 8'd31;

    // One result beat
    typedef struct packed {
        logic  kind;
        byte_t data_byte;
        half_t win_columns;
        half_t win_rows;
    } result_t;

endpackage

// File: src/telnet_iac_stripper_unit.sv
// Telnet receive filter: strips IAC sequences and captures NAWS window size.
// Depends on tis_pkg for codes, types and the output beat layout.

// Takes one received telnet byte per beat and gives zero or one result beat
// per byte. A byte sits in an input register, is decoded by a small phase
// machine and its result (if any) lands in an output register. One byte is
// taken every clock cycle while the output side keeps up. Bytes that
// produce no result (IAC commands, LF or NUL after CR, NAWS payload) are
// consumed silently. A terminal data beat carries kind 0 on tuser and the
// byte in tdata[7:0]; a window size beat carries kind 1 with columns in
// tdata[23:8] and rows in tdata[39:24]. Unused fields of a beat are zero.
module telnet_iac_stripper_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tis_pkg::byte_t    s_tdata,   // [7:0] in_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output tis_pkg::out_data_t m_tdata,  // [7:0] data_byte, [23:8] win_columns,
                                         // [39:24] win_rows
    output logic [0:0]        m_tuser    // [0] kind
);

    import tis_pkg::*;

    // Phase codes
    localparam logic [3:0] PH_NORMAL   = 4'd0;
    localparam logic [3:0] PH_AFTER_CR = 4'd1;
    localparam logic [3:0] PH_CMD      = 4'd2;
    localparam logic [3:0] PH_SB_OPT   = 4'd3;
    localparam logic [3:0] PH_SKIP     = 4'd4;
    localparam logic [3:0] PH_SIZE0    = 4'd5;
    localparam logic [3:0] PH_SIZE1    = 4'd6;
    localparam logic [3:0] PH_SIZE2    = 4'd7;
    localparam logic [3:0] PH_SIZE3    = 4'd8;
    localparam logic [3:0] PH_TRAIL0   = 4'd9;
    localparam logic [3:0] PH_TRAIL1   = 4'd10;

    logic        in_valid_reg;
    byte_t       in_byte_reg;
    logic [3:0]  phase_reg, phase_next;
    logic [31:0] size_hold_reg, size_hold_next;
    logic        out_valid_reg;
    result_t     out_reg, res;
    logic        res_valid;
    logic        out_free;
    logic        advance;

    // Handshake: output register frees when empty or taken this cycle
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // Byte grammar decode
    always_comb
    begin
        byte_t b;
        logic  plain;
        b              = in_byte_reg;
        plain          = 1'b0;
        phase_next     = phase_reg;
        size_hold_next = size_hold_reg;
        res_valid      = 1'b0;
        res            = '0;
        res.kind       = KIND_DATA;
        res.data_byte  = b;

        case (phase_reg)
            PH_AFTER_CR:
            begin
                if (b == CH_LF || b == CH_NUL)
                begin
                    phase_next = PH_NORMAL;
                end
                else
                begin
                    plain = 1'b1;
                end
            end
            PH_CMD:
            begin
                if (b == TN_NOP)
                begin
                    phase_next = PH_NORMAL;
                end
                else if (b == TN_IAC)
                begin
                    // escaped 255 passes through, does not arm the CR rule
                    phase_next = PH_NORMAL;
                    res_valid  = 1'b1;
                end
                else
                begin
                    phase_next = (b == TN_SB) ? PH_SB_OPT : PH_SKIP;
                end
            end
            PH_SB_OPT:
            begin
                phase_next = (b == TN_NAWS) ? PH_SIZE0 : PH_NORMAL;
            end
            PH_SKIP:
            begin
                phase_next = PH_NORMAL;
            end
            PH_SIZE0, PH_SIZE1, PH_SIZE2, PH_SIZE3:
            begin
                size_hold_next = {size_hold_reg[23:0], b};
                phase_next     = phase_reg + 4'd1;
            end
            PH_TRAIL0:
            begin
                phase_next = PH_TRAIL1;
            end
            PH_TRAIL1:
            begin
                phase_next      = PH_NORMAL;
                res_valid       = 1'b1;
                res.kind        = KIND_SIZE;
                res.data_byte   = '0;
                res.win_columns = size_hold_reg[31:16];
                res.win_rows    = size_hold_reg[15:0];
            end
            default:
            begin
                plain = 1'b1;
            end
        endcase

        // Normal data handling, shared by the CR phase
        if (plain)
        begin
            if (b == TN_IAC)
            begin
                phase_next = PH_CMD;
            end
            else
            begin
                phase_next = (b == CH_CR) ? PH_AFTER_CR : PH_NORMAL;
                res_valid  = 1'b1;
            end
        end
    end

    // Phase and size capture state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_NORMAL;
            size_hold_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            size_hold_reg <= size_hold_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_reg.win_rows, out_reg.win_columns, out_reg.data_byte};
    assign m_tuser[0] = out_reg.kind;

endmodule

// File: test/telnet_iac_stripper_unit_test.sv
// Self-checking bench for telnet_iac_stripper_unit: directed and random byte streams
// run through a behavioural filter model in a small scoreboard class.
// Depends on tis_pkg and the telnet_iac_stripper_unit RTL only.
`timescale 1ns / 100ps

import tis_pkg::*;

// Behavioural telnet filter plus the queue of result beats still owed by the block
class naws_filter_board;

    typedef enum logic [3:0]
    {
        ST_NORMAL,
        ST_AFTER_CR,
        ST_CMD,
        ST_SB_OPT,
        ST_SKIP,
        ST_SIZE0,
        ST_SIZE1,
        ST_SIZE2,
        ST_SIZE3,
        ST_TRAIL0,
        ST_TRAIL1
    } filter_state_e;

    filter_state_e state;
    logic [31:0]   size_hold;
    result_t       owed_beats[$];
    int unsigned   fail_count;

    function new();
        state      = ST_NORMAL;
        size_hold  = '0;
        fail_count = 0;
    endfunction

    function void note_failure(string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", what);
    endfunction

    function void owe_data(byte_t b);
        result_t r;
        r.kind        = KIND_DATA;
        r.data_byte   = b;
        r.win_columns = '0;
        r.win_rows    = '0;
        owed_beats.push_back(r);
    endfunction

    // Byte seen outside any command: IAC opens a command, CR arms the LF/NUL rule
    function void plain_byte(byte_t b);
        if (b == TN_IAC)
        begin
            state = ST_CMD;
        end
        else
        begin
            state = (b == CH_CR) ? ST_AFTER_CR : ST_NORMAL;
            owe_data(b);
        end
    endfunction

    // Called for every accepted input beat
    function void take_byte(byte_t b);
        result_t r;
        case (state)
            ST_AFTER_CR:
                if (b == CH_LF || b == CH_NUL)
                    state = ST_NORMAL;
                else
                    plain_byte(b);
            ST_CMD:
                if (b == TN_NOP)
                begin
                    state = ST_NORMAL;
                end
                else if (b == TN_IAC)
                begin
                    state = ST_NORMAL;
                    owe_data(b);
                end
                else
                begin
                    state = (b == TN_SB) ? ST_SB_OPT : ST_SKIP;
                end
            ST_SB_OPT:
                state = (b == TN_NAWS) ? ST_SIZE0 : ST_NORMAL;
            ST_SKIP:
                state = ST_NORMAL;
            ST_SIZE0, ST_SIZE1, ST_SIZE2, ST_SIZE3:
            begin
                size_hold = {size_hold[23:0], b};
                state     = filter_state_e'(state + 4'd1);
            end
            ST_TRAIL0:
                state = ST_TRAIL1;
            ST_TRAIL1:
            begin
                state         = ST_NORMAL;
                r.kind        = KIND_SIZE;
                r.data_byte   = '0;
                r.win_columns = size_hold[31:16];
                r.win_rows    = size_hold[15:0];
                owed_beats.push_back(r);
            end
            default:
                plain_byte(b);
        endcase
    endfunction

    // Called for every accepted output beat
    function void check_beat(logic kind, out_data_t tdata);
        result_t want;
        byte_t   got_byte;
        half_t   got_cols;
        half_t   got_rows;
        got_byte = tdata[7:0];
        got_cols = tdata[23:8];
        got_rows = tdata[39:24];
        if (owed_beats.size() == 0)
        begin
            note_failure($sformatf("MISMATCH: unexpected beat kind %0d data %02h cols %0d rows %0d",
                                   kind, got_byte, got_cols, got_rows));
        end
        else
        begin
            want = owed_beats.pop_front();
            if (kind !== want.kind || got_byte !== want.data_byte ||
                got_cols !== want.win_columns || got_rows !== want.win_rows)
                note_failure($sformatf({"MISMATCH: expected kind %0d data %02h cols %0d rows %0d,",
                                        " got kind %0d data %02h cols %0d rows %0d"},
                                       want.kind, want.data_byte, want.win_columns,
                                       want.win_rows, kind, got_byte, got_cols, got_rows));
        end
    endfunction

    // Anything still owed once the block has gone quiet
    function void flag_leftovers();
        result_t want;
        while (owed_beats.size() > 0)
        begin
            want = owed_beats.pop_front();
            note_failure($sformatf("MISSING: kind %0d data %02h cols %0d rows %0d never arrived",
                                   want.kind, want.data_byte, want.win_columns, want.win_rows));
        end
    endfunction

endclass

module telnet_iac_stripper_unit_test;

    localparam int unsigned RANDOM_BYTES = 1250;
    localparam int unsigned QUIET_TAIL   = 200;

    logic      clk;
    logic      rst_n;
    logic      s_tvalid;
    logic      s_tready;
    byte_t     s_tdata;
    logic      m_tvalid;
    logic      m_tready;
    out_data_t m_tdata;
    logic [0:0] m_tuser;

    naws_filter_board board;
    int unsigned      bytes_sent;
    int unsigned      idle_pct;
    int unsigned      stall_left;

    // Directed stream: extremes, CR rules, every IAC form, NAWS with 255 in the size data
    byte_t directed_bytes[] = '{
        8'h00, 8'h80,
        CH_CR, CH_LF,
        CH_CR, CH_NUL,
        CH_CR, CH_CR, CH_LF,
        TN_IAC, TN_NOP,
        CH_CR, TN_IAC, TN_IAC, CH_LF,
        TN_IAC, TN_SB, TN_NAWS, 8'hFF, 8'hFF, 8'h00, 8'h18, TN_IAC, 8'hF0,
        TN_IAC, TN_SB, 8'h18, 8'h42,
        TN_IAC, 8'hFB, 8'h01,
        8'h7F
    };

    telnet_iac_stripper_unit DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Drive one byte from a falling edge, hold until accepted, return on the next falling edge
    task automatic send_byte(input byte_t b);
        int unsigned gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        board.take_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    // One random run: mostly well-formed telnet sequences, some raw noise
    task automatic send_random_run();
        int unsigned pick;
        byte_t       b;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            send_byte(byte_t'($urandom_range(0, 254)));
        end
        else if (pick < 45)
        begin
            send_byte(CH_CR);
            case ($urandom_range(0, 2))
                0: send_byte(CH_LF);
                1: send_byte(CH_NUL);
                default: send_byte(byte_t'($urandom_range(0, 255)));
            endcase
        end
        else if (pick < 52)
        begin
            send_byte(TN_IAC);
            send_byte(TN_NOP);
        end
        else if (pick < 59)
        begin
            send_byte(TN_IAC);
            send_byte(TN_IAC);
        end
        else if (pick < 75)
        begin
            send_byte(TN_IAC);
            send_byte(TN_SB);
            send_byte(TN_NAWS);
            repeat (6) send_byte(byte_t'($urandom_range(0, 255)));
        end
        else if (pick < 82)
        begin
            do
                b = byte_t'($urandom_range(0, 255));
            while (b == TN_NAWS);
            send_byte(TN_IAC);
            send_byte(TN_SB);
            send_byte(b);
        end
        else if (pick < 90)
        begin
            do
                b = byte_t'($urandom_range(0, 254));
            while (b == TN_NOP || b == TN_SB);
            send_byte(TN_IAC);
            send_byte(b);
            send_byte(byte_t'($urandom_range(0, 255)));
        end
        else
        begin
            send_byte(byte_t'($urandom_range(0, 255)));
        end
    endtask

    // Sink side: random stall bursts, driven on the falling edge
    initial
    begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (rst_n && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= rst_n;
            end
        end
    end

    // Result beats are checked at the rising edge that takes them
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_beat(m_tuser[0], m_tdata);
    end

    // Stimulus and end of run
    initial
    begin
        board      = new();
        bytes_sent = 0;
        idle_pct   = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        // Idle rate changes every hundred bytes; the tail runs flat out
        while (bytes_sent < directed_bytes.size() + RANDOM_BYTES)
        begin
            if (bytes_sent % 100 < 3)
            begin
                case ($urandom_range(0, 3))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    2: idle_pct = 25;
                    default: idle_pct = 50;
                endcase
            end
            if (bytes_sent + QUIET_TAIL > directed_bytes.size() + RANDOM_BYTES)
                idle_pct = 0;
            send_random_run();
        end
        s_tvalid <= 1'b0;

        // Drain, then allow the pipeline latency to pass
        for (int w = 0; w < 5000 && board.owed_beats.size() > 0; w++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        board.flag_leftovers();

        if (board.fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
